[hdl/assert_macros.svh]
// Concurrent assertion helpers used by the assertion checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion on the standard clk_i / rst_ni pair.
`define SPMD_ASSERT(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[hdl/spmd_pkg.sv]
`default_nettype none

package spmd_pkg;

  // Operation codes
  typedef enum logic [1:0] {
    OP_POST    = 2'd0,
    OP_ACTION  = 2'd1,
    OP_MASK    = 2'd2,
    OP_DELIVER = 2'd3
  } op_e;

  // Mask update modes
  typedef enum logic [1:0] {
    HOW_BLOCK   = 2'd0,
    HOW_UNBLOCK = 2'd1,
    HOW_SET     = 2'd2,
    HOW_INVALID = 2'd3
  } how_e;

  // Delivery outcome
  typedef enum logic [2:0] {
    ACT_NONE = 3'd0,
    ACT_TERM = 3'd1,
    ACT_STOP = 3'd2,
    ACT_IGN  = 3'd3,
    ACT_CALL = 3'd4
  } act_e;

  localparam logic [63:0] KERNEL_BASE    = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] HANDLER_DFL    = 64'd0;
  localparam logic [63:0] HANDLER_IGNORE = 64'd1;
  localparam logic [5:0]  SIG_KILL       = 6'd9;
  localparam logic [5:0]  SIG_STOP       = 6'd19;
  localparam logic [7:0]  EXIT_BASE      = 8'd128;
  // Kill and stop can never be blocked
  localparam logic [63:0] UNBLOCKABLE    = (64'd1 << (SIG_KILL - 6'd1)) |
                                           (64'd1 << (SIG_STOP - 6'd1));

  // Input transaction
  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  signal_number;
    logic        has_new_handler;
    logic [63:0] new_handler;
    logic        has_mask_value;
    logic [1:0]  how;
    logic [63:0] mask_value;
  } spmd_req_t;

  // Result transaction
  typedef struct packed {
    logic        status;
    logic [63:0] old_handler;
    logic [63:0] old_mask;
    logic [4:0]  delivered_signal;
    logic [2:0]  action;
    logic        user_fallback;
    logic [7:0]  exit_code;
  } spmd_rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic dispatch;
    logic pick;
    logic eval;
    logic emit;
  } spmd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] opcode;
    logic       action_ok;
    logic       none_ready;
    logic       handler_ignore;
  } spmd_stat_t;

  // Default disposition of a signal
  function automatic act_e default_class(input logic [5:0] sig);
    act_e res;
    case (sig) inside
      6'd17, 6'd18, 6'd23, 6'd28: res = ACT_IGN;
      [6'd19:6'd22]:              res = ACT_STOP;
      default:                    res = ACT_TERM;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

[hdl/spmd_ctrl.sv]
`default_nettype none

module spmd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  spmd_pkg::spmd_stat_t   stat_i,
  output spmd_pkg::spmd_cmd_t    cmd_o
);
  import spmd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_DISPATCH = 4'b0010,
    ST_PICK     = 4'b0100,
    ST_EVAL     = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd_o.dispatch = 1'b1;
        if (stat_i.opcode == OP_DELIVER) begin
          state_d = ST_PICK;
        end else if (stat_i.opcode == OP_ACTION && stat_i.action_ok) begin
          state_d = ST_EVAL;
        end else begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_PICK: begin
        cmd_o.pick = 1'b1;
        if (stat_i.none_ready) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        // ignored signal: drop it and keep scanning
        if (stat_i.opcode == OP_DELIVER && stat_i.handler_ignore) begin
          state_d = ST_PICK;
        end else begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

[hdl/spmd_datapath.sv]
`default_nettype none

module spmd_datapath #(
  parameter int NUM_SIGNALS = 31
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  spmd_pkg::spmd_cmd_t    cmd_i,
  input  spmd_pkg::spmd_req_t    req_i,
  output spmd_pkg::spmd_stat_t   stat_o,
  output spmd_pkg::spmd_rsp_t    rsp_o,
  output logic                   rsp_valid_o
);
  import spmd_pkg::*;

  localparam int          IW      = $clog2(NUM_SIGNALS);
  localparam logic [5:0]  SIG_MAX = 6'(NUM_SIGNALS);

  spmd_req_t              req_q;
  logic [NUM_SIGNALS-1:0] pending_q, pending_d;
  logic [63:0]            blocked_q, blocked_d;
  logic [NUM_SIGNALS-1:0] hvalid_q;
  logic [63:0]            handler_mem [NUM_SIGNALS];
  logic [63:0]            rdata_q;
  logic                   rvalid_q;
  logic [IW-1:0]          idx_q, pick_idx, sig_idx, raddr;
  spmd_rsp_t              rsp_q, rsp_d;
  logic                   rsp_valid_q;

  logic                   sig_ok, action_ok, mem_we;
  logic [NUM_SIGNALS-1:0] ready;
  logic [63:0]            handler;
  logic [5:0]             dsig;
  act_e                   dclass, dact;

  // Latched command
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  // Argument checks
  assign sig_ok    = (req_q.signal_number != 6'd0) && (req_q.signal_number <= SIG_MAX);
  assign action_ok = sig_ok && (req_q.signal_number != SIG_KILL) &&
                     (req_q.signal_number != SIG_STOP);
  assign sig_idx   = IW'(req_q.signal_number - 6'd1);

  // Lowest unblocked pending signal
  assign ready = pending_q & ~blocked_q[NUM_SIGNALS-1:0];
  always_comb begin
    pick_idx = '0;
    for (int i = NUM_SIGNALS - 1; i >= 0; i--) begin
      if (ready[i]) begin
        pick_idx = IW'(i);
      end
    end
  end

  // Handler table: one read port, one write port
  assign raddr  = cmd_i.pick ? pick_idx : (sig_ok ? sig_idx : '0);
  assign mem_we = cmd_i.eval && (req_q.opcode == OP_ACTION) && req_q.has_new_handler;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      handler_mem[sig_idx] <= req_q.new_handler;
    end
    rdata_q  <= handler_mem[raddr];
    rvalid_q <= hvalid_q[raddr];
  end

  // Entries never written read as default
  assign handler = rvalid_q ? rdata_q : HANDLER_DFL;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pick) begin
      idx_q <= pick_idx;
    end
  end

  // Pending and blocked updates
  always_comb begin
    pending_d = pending_q;
    blocked_d = blocked_q;
    if (cmd_i.dispatch && req_q.opcode == OP_POST && sig_ok) begin
      pending_d[sig_idx] = 1'b1;
    end
    if (cmd_i.eval && req_q.opcode == OP_DELIVER) begin
      pending_d[idx_q] = 1'b0;
    end
    if (cmd_i.dispatch && req_q.opcode == OP_MASK && req_q.has_mask_value &&
        req_q.how != HOW_INVALID) begin
      case (req_q.how)
        HOW_BLOCK:   blocked_d = blocked_q | req_q.mask_value;
        HOW_UNBLOCK: blocked_d = blocked_q & ~req_q.mask_value;
        default:     blocked_d = req_q.mask_value;
      endcase
      blocked_d = blocked_d & ~UNBLOCKABLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      blocked_q   <= '0;
      hvalid_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      pending_q   <= pending_d;
      blocked_q   <= blocked_d;
      rsp_valid_q <= cmd_i.emit;
      if (mem_we) begin
        hvalid_q[sig_idx] <= 1'b1;
      end
    end
  end

  // Delivery decision for the picked signal
  assign dsig   = 6'(idx_q) + 6'd1;
  assign dclass = default_class(dsig);
  always_comb begin
    if (handler == HANDLER_DFL) begin
      dact = dclass;
    end else if (handler >= KERNEL_BASE) begin
      dact = ACT_CALL;
    end else begin
      dact = dclass;
    end
  end

  // Result assembly
  always_comb begin
    rsp_d = '0;
    if (cmd_i.dispatch) begin
      case (req_q.opcode)
        OP_POST:   rsp_d.status = !sig_ok;
        OP_ACTION: rsp_d.status = !action_ok;
        OP_MASK: begin
          rsp_d.old_mask = blocked_q;
          rsp_d.status   = req_q.has_mask_value && (req_q.how == HOW_INVALID);
        end
        default: rsp_d = '0;
      endcase
    end else if (cmd_i.eval) begin
      if (req_q.opcode == OP_ACTION) begin
        rsp_d.old_handler = handler;
      end else begin
        rsp_d.delivered_signal = dsig[4:0];
        rsp_d.action           = dact;
        rsp_d.old_handler      = (dact == ACT_CALL) ? handler : 64'd0;
        rsp_d.user_fallback    = (handler != HANDLER_DFL) && (handler < KERNEL_BASE);
        rsp_d.exit_code        = (dact == ACT_TERM) ? (EXIT_BASE + 8'(dsig)) : 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rsp_q <= rsp_d;
    end
  end

  assign stat_o.opcode         = req_q.opcode;
  assign stat_o.action_ok      = action_ok;
  assign stat_o.none_ready     = ~|ready;
  assign stat_o.handler_ignore = (handler == HANDLER_IGNORE);

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

endmodule

`default_nettype wire

[hdl/signal_pending_mask_delivery_unit.sv]
// From accept to result strobe: post, mask and refused action pass the dispatch
// state only; an accepted action adds the evaluate state; deliver passes dispatch,
// pick and evaluate, back to pick per ignored signal skipped (emits after pick if
// none is ready). One transaction at a time; busy drops in the strobe cycle.
// Reset clears pending bits, blocked mask and handler valid bits at once; the
// result strobe lasts one cycle and the receiver cannot stall it.
`default_nettype none

module signal_pending_mask_delivery_unit #(
  parameter int NUM_SIGNALS = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  spmd_pkg::spmd_req_t  req_i,
  output spmd_pkg::spmd_rsp_t  rsp_o,
  output logic                 rsp_valid_o
);
  import spmd_pkg::*;

  spmd_cmd_t  cmd;
  spmd_stat_t stat;

  // Sequencer
  spmd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // State, handler table and result register
  spmd_datapath #(
    .NUM_SIGNALS (NUM_SIGNALS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .stat_o      (stat),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o)
  );

endmodule

`default_nettype wire

[hdl/spmd_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module spmd_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 start,
  input wire                 busy,
  input spmd_pkg::spmd_rsp_t rsp_o,
  input wire                 rsp_valid_o
);
  import spmd_pkg::*;

  logic fail_rsp, no_dlv, term_rsp;

  // Result qualifiers
  assign fail_rsp = rsp_valid_o && rsp_o.status;
  assign no_dlv   = (rsp_o.action == ACT_NONE) && (rsp_o.delivered_signal == 5'd0);
  assign term_rsp = rsp_valid_o && (rsp_o.action == ACT_TERM);

  // Accepted transaction keeps the unit busy next cycle
  `SPMD_ASSERT(a_accept_busy, (start && !busy) |=> busy, "busy not raised after accept")

  // Results never come back to back
  `SPMD_ASSERT(a_strobe_gap, rsp_valid_o |=> !rsp_valid_o, "result strobe held over two cycles")

  // Result strobe lands while the unit is free
  `SPMD_ASSERT(a_strobe_idle, rsp_valid_o |-> !busy, "result strobe while busy")

  // Failed status never carries a delivery
  `SPMD_ASSERT(a_status_nodlv, fail_rsp |-> no_dlv, "delivery on failed status")

  // Terminate carries an exit code with the high bit set
  `SPMD_ASSERT(a_term_code, term_rsp |-> rsp_o.exit_code[7], "terminate without exit code")

endmodule

bind signal_pending_mask_delivery_unit spmd_checker u_spmd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .rsp_o       (rsp_o),
  .rsp_valid_o (rsp_valid_o)
);

`default_nettype wire

[dv/signal_pending_mask_delivery_unit_tb.sv]
`timescale 1ns / 1ps

module signal_pending_mask_delivery_unit_tb;
  import spmd_pkg::*;

  localparam int NSIG        = 31;
  localparam int ITEM_TOTAL  = 1350;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 80;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  logic      busy;
  spmd_req_t req_i  = '0;
  spmd_rsp_t rsp_o;
  logic      rsp_valid_o;

  signal_pending_mask_delivery_unit #(.NUM_SIGNALS(NSIG)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_o      (rsp_o),
    .rsp_valid_o(rsp_valid_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Shadow copy of the signal context
  logic [NSIG-1:0] pend_bits;
  logic [63:0]     blocked_word;
  logic [63:0]     handler_tbl [NSIG];

  spmd_req_t op_backlog_q [$];
  spmd_rsp_t awaited_rsp_q [$];

  int err_cnt      = 0;
  int plan_total   = 0;
  int issued_cnt   = 0;
  int rsp_cnt      = 0;
  int op_cnt [4]   = '{0, 0, 0, 0};
  int taken_cnt    = 0;
  int called_cnt   = 0;
  int fallback_cnt = 0;
  int idle_cycles  = 0;

  function automatic bit sig_ok(input logic [5:0] s);
    return (s >= 6'd1) && (s <= 6'(NSIG));
  endfunction

  // Default disposition per signal number
  function automatic act_e dfl_disposition(input int s);
    case (s)
      17, 18, 23, 28: return ACT_IGN;
      19, 20, 21, 22: return ACT_STOP;
      default:        return ACT_TERM;
    endcase
  endfunction

  // Expected response for one transaction; updates the shadow context
  function automatic spmd_rsp_t compute_route_result(input spmd_req_t rq);
    spmd_rsp_t       r;
    logic [NSIG-1:0] ready;
    logic [63:0]     h;
    act_e            a;
    bit              done;
    r = '0;
    case (op_e'(rq.opcode))
      OP_POST: begin
        if (sig_ok(rq.signal_number)) pend_bits[rq.signal_number - 6'd1] = 1'b1;
        else r.status = 1'b1;
      end
      OP_ACTION: begin
        if (!sig_ok(rq.signal_number) || rq.signal_number == SIG_KILL ||
            rq.signal_number == SIG_STOP) begin
          r.status = 1'b1;
        end else begin
          r.old_handler = handler_tbl[rq.signal_number - 6'd1];
          if (rq.has_new_handler) handler_tbl[rq.signal_number - 6'd1] = rq.new_handler;
        end
      end
      OP_MASK: begin
        r.old_mask = blocked_word;
        if (rq.has_mask_value) begin
          case (how_e'(rq.how))
            HOW_BLOCK:   blocked_word = blocked_word | rq.mask_value;
            HOW_UNBLOCK: blocked_word = blocked_word & ~rq.mask_value;
            HOW_SET:     blocked_word = rq.mask_value;
            default:     r.status = 1'b1;
          endcase
          blocked_word = blocked_word & ~UNBLOCKABLE;
        end
      end
      default: begin
        // lowest unblocked pending first; ignored handlers are consumed silently
        ready = pend_bits & ~blocked_word[NSIG-1:0];
        done  = 1'b0;
        for (int s = 1; s <= NSIG; s++) begin
          if (!done && ready[s-1]) begin
            pend_bits[s-1] = 1'b0;
            h = handler_tbl[s-1];
            if (h != HANDLER_IGNORE) begin
              done = 1'b1;
              r.delivered_signal = s[4:0];
              if (h == HANDLER_DFL) begin
                a = dfl_disposition(s);
              end else if (h >= KERNEL_BASE) begin
                a = ACT_CALL;
                r.old_handler = h;
              end else begin
                a = dfl_disposition(s);
                r.user_fallback = 1'b1;
              end
              r.action = a;
              if (a == ACT_TERM) r.exit_code = EXIT_BASE + s[7:0];
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_handler();
    case ($urandom_range(6))
      0:       return HANDLER_DFL;
      1:       return HANDLER_IGNORE;
      2:       return KERNEL_BASE | rand64();
      3:       return rand64() & 64'h7FFF_FFFF_FFFF_FFFF;
      4:       return ($urandom_range(1) != 0) ? KERNEL_BASE : KERNEL_BASE - 64'd1;
      5:       return HANDLER_DFL;
      default: return rand64();
    endcase
  endfunction

  // Few set bits keep most signals deliverable
  function automatic logic [63:0] sparse_mask();
    logic [63:0] m;
    m = '0;
    repeat ($urandom_range(3)) m[$urandom_range(63)] = 1'b1;
    return m;
  endfunction

  function automatic spmd_req_t make_random_op();
    spmd_req_t rq;
    int        pick;
    rq.opcode          = 2'($urandom_range(3));
    rq.signal_number   = 6'($urandom_range(63));
    rq.has_new_handler = 1'($urandom_range(1));
    rq.new_handler     = rand64();
    rq.has_mask_value  = 1'($urandom_range(1));
    rq.how             = 2'($urandom_range(3));
    rq.mask_value      = rand64();
    pick = $urandom_range(99);
    if (pick < 35) rq.opcode = OP_POST;
    else if (pick < 55) rq.opcode = OP_ACTION;
    else if (pick < 68) rq.opcode = OP_MASK;
    else rq.opcode = OP_DELIVER;
    // mostly valid signal numbers, occasional out-of-range noise
    if ($urandom_range(99) < 88) rq.signal_number = 6'($urandom_range(NSIG, 1));
    if (rq.opcode == OP_ACTION) begin
      rq.has_new_handler = ($urandom_range(99) < 75);
      rq.new_handler     = pick_handler();
    end else if (rq.opcode == OP_MASK) begin
      rq.has_mask_value = ($urandom_range(99) < 85);
      pick = $urandom_range(99);
      if (pick < 40) begin
        rq.how = HOW_UNBLOCK;
        if ($urandom_range(1) != 0) rq.mask_value = '1;
      end else if (pick < 65) begin
        rq.how = HOW_BLOCK;
        if ($urandom_range(9) != 0) rq.mask_value = sparse_mask();
      end else if (pick < 90) begin
        rq.how = HOW_SET;
        if ($urandom_range(9) != 0) rq.mask_value = sparse_mask();
      end else begin
        rq.how = HOW_INVALID;
      end
    end
    return rq;
  endfunction

  task automatic add_op(input op_e op, input int sig, input bit hh, input logic [63:0] nh,
                        input bit hm, input how_e hw, input logic [63:0] mv);
    spmd_req_t rq;
    rq.opcode          = op;
    rq.signal_number   = 6'(sig);
    rq.has_new_handler = hh;
    rq.new_handler     = nh;
    rq.has_mask_value  = hm;
    rq.how             = hw;
    rq.mask_value      = mv;
    op_backlog_q.push_back(rq);
  endtask

  task automatic show_field_miss(input string fld, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
    err_cnt++;
  endtask

  // Sender idling: 23%, then 79%, then none
  function automatic int idle_pct();
    if (issued_cnt < plan_total / 3) return 23;
    if (issued_cnt < (2 * plan_total) / 3) return 79;
    return 0;
  endfunction

  // Driver: predict on accept, then present the next transaction or idle
  always @(posedge clk_i) begin
    if (rst_ni && !(start && busy)) begin
      if (start && !busy) begin
        awaited_rsp_q.push_back(compute_route_result(req_i));
        op_cnt[req_i.opcode]++;
      end
      if (op_backlog_q.size() > 0 && $urandom_range(99) >= idle_pct()) begin
        req_i <= op_backlog_q.pop_front();
        start <= 1'b1;
        issued_cnt++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: one-cycle result strobe, compare against oldest expectation
  always @(posedge clk_i) begin
    spmd_rsp_t want;
    if (rst_ni && rsp_valid_o === 1'b1) begin
      rsp_cnt++;
      if (awaited_rsp_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, rsp_o);
        err_cnt++;
      end else begin
        want = awaited_rsp_q.pop_front();
        if (want.delivered_signal != 0) taken_cnt++;
        if (want.action == ACT_CALL) called_cnt++;
        if (want.user_fallback) fallback_cnt++;
        if (rsp_o.status !== want.status)
          show_field_miss("status", 64'(want.status), 64'(rsp_o.status));
        if (rsp_o.old_handler !== want.old_handler)
          show_field_miss("old_handler", want.old_handler, rsp_o.old_handler);
        if (rsp_o.old_mask !== want.old_mask)
          show_field_miss("old_mask", want.old_mask, rsp_o.old_mask);
        if (rsp_o.delivered_signal !== want.delivered_signal)
          show_field_miss("delivered_signal", 64'(want.delivered_signal),
                          64'(rsp_o.delivered_signal));
        if (rsp_o.action !== want.action)
          show_field_miss("action", 64'(want.action), 64'(rsp_o.action));
        if (rsp_o.user_fallback !== want.user_fallback)
          show_field_miss("user_fallback", 64'(want.user_fallback), 64'(rsp_o.user_fallback));
        if (rsp_o.exit_code !== want.exit_code)
          show_field_miss("exit_code", 64'(want.exit_code), 64'(rsp_o.exit_code));
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || rsp_valid_o === 1'b1) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("FAIL signal_pending_mask_delivery_unit");
        $finish;
      end
    end
  end

  initial begin
    pend_bits    = '0;
    blocked_word = '0;
    foreach (handler_tbl[i]) handler_tbl[i] = HANDLER_DFL;

    // Directed: bad signals, refused actions, handler kinds
    add_op(OP_POST,   0,  0, '1, 1, HOW_INVALID, '1);
    add_op(OP_POST,   63, 1, '1, 1, HOW_INVALID, '1);
    add_op(OP_ACTION, 9,  1, KERNEL_BASE, 0, HOW_BLOCK, '0);
    add_op(OP_ACTION, 19, 1, KERNEL_BASE, 0, HOW_BLOCK, '0);
    add_op(OP_ACTION, 32, 1, '1, 0, HOW_BLOCK, '0);
    add_op(OP_ACTION, 31, 1, KERNEL_BASE, 0, HOW_BLOCK, '0);
    add_op(OP_ACTION, 31, 0, '0, 0, HOW_BLOCK, '0);
    add_op(OP_ACTION, 2,  1, HANDLER_IGNORE, 0, HOW_BLOCK, '0);
    add_op(OP_ACTION, 5,  1, 64'h0000_7FFF_1234_0000, 0, HOW_BLOCK, '0);
    add_op(OP_ACTION, 17, 1, '1, 0, HOW_BLOCK, '0);
    add_op(OP_POST, 1,  0, '0, 0, HOW_BLOCK, '0);
    add_op(OP_POST, 2,  0, '0, 0, HOW_BLOCK, '0);
    add_op(OP_POST, 5,  0, '0, 0, HOW_BLOCK, '0);
    add_op(OP_POST, 17, 0, '0, 0, HOW_BLOCK, '0);
    add_op(OP_POST, 20, 0, '0, 0, HOW_BLOCK, '0);
    add_op(OP_POST, 31, 0, '0, 0, HOW_BLOCK, '0);
    add_op(OP_POST, 9,  0, '0, 0, HOW_BLOCK, '0);
    // mask: no value, block all (kill/stop stay open), invalid mode, deliver, unblock all
    add_op(OP_MASK, 63, 1, '1, 0, HOW_INVALID, '1);
    add_op(OP_MASK, 0,  0, '0, 1, HOW_BLOCK, '1);
    add_op(OP_MASK, 0,  0, '0, 1, HOW_INVALID, '0);
    add_op(OP_DELIVER, 0, 0, '0, 0, HOW_BLOCK, '0);
    add_op(OP_MASK, 0,  0, '0, 1, HOW_UNBLOCK, '1);
    // default, ignored-then-fallback, kernel call, stop, call, nothing left
    repeat (6) add_op(OP_DELIVER, 63, 1, '1, 1, HOW_INVALID, '1);
    add_op(OP_MASK, 0,  0, '0, 1, HOW_SET, 64'hFFFF_FFFF_0000_0000);
    add_op(OP_POST, 28, 0, '0, 0, HOW_BLOCK, '0);
    add_op(OP_DELIVER, 0, 0, '0, 0, HOW_BLOCK, '0);

    while (op_backlog_q.size() < ITEM_TOTAL) op_backlog_q.push_back(make_random_op());
    plan_total = op_backlog_q.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (op_backlog_q.size() != 0 || start || awaited_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (awaited_rsp_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, awaited_rsp_q.size());
      err_cnt++;
    end

    $display("Ran %0d transactions: %0d post, %0d action, %0d mask, %0d deliver.",
             rsp_cnt, op_cnt[OP_POST], op_cnt[OP_ACTION], op_cnt[OP_MASK],
             op_cnt[OP_DELIVER]);
    $display("Deliveries: %0d signals taken, %0d handler calls, %0d user fallbacks.",
             taken_cnt, called_cnt, fallback_cnt);
    if (err_cnt == 0) begin
      $display("PASS signal_pending_mask_delivery_unit");
    end else begin
      $display("FAIL signal_pending_mask_delivery_unit");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/spmd_pkg.sv
hdl/spmd_ctrl.sv
hdl/spmd_datapath.sv
hdl/signal_pending_mask_delivery_unit.sv
hdl/spmd_checker.sv
dv/signal_pending_mask_delivery_unit_tb.sv
